[hw/rtl/gmr_pkg.sv]
// Shared types and constants for the grid min-redirect path search.
`default_nettype none
package gmr_pkg;
    localparam int COST_W = 17;
    localparam int OUT_W  = 16;
    localparam int CODE_W = 3;

    typedef logic [COST_W-1:0] t_cost;
    typedef logic [CODE_W-1:0] t_code;

    localparam t_cost COST_UNREACHED = 17'h1FFFF;

    localparam t_code CODE_UP    = 3'd0;
    localparam t_code CODE_DOWN  = 3'd1;
    localparam t_code CODE_LEFT  = 3'd2;
    localparam t_code CODE_RIGHT = 3'd3;
    localparam t_code CODE_GOAL  = 3'd4;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_STEP = 2'd2;

    // One neighbor relaxation: a reached source cost plus a redirection penalty.
    typedef struct packed {
        logic  en;
        t_cost cost;
        t_code code;
        t_code want;
    } t_relax_req;
endpackage
`default_nettype wire

[hw/rtl/gmr_relax.sv]
// Shared relax unit: one add and one compare per cycle.
`default_nettype none
module gmr_relax (
    input  wire gmr_pkg::t_relax_req i_req,
    input  wire gmr_pkg::t_cost      i_cur,
    output gmr_pkg::t_cost           o_next
);
    import gmr_pkg::*;

    t_cost w_cand;

    always_comb begin
        w_cand = i_req.cost + ((i_req.code == i_req.want) ? t_cost'(0) : t_cost'(1));
        o_next = i_cur;
        if (i_req.en && (i_req.cost != COST_UNREACHED) && (w_cand < i_cur)) begin
            o_next = w_cand;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/grid_min_redirect_path_dp.sv]
// A load word is written into the grid store when it is taken. A run word sweeps
// all rows*cols cells once per layer, for at most step_limit layers; the sweep
// ends early once a layer repeats the one two moves before it. Each cell runs in
// sub-steps: one cost memory read port serves four neighbors and the cell itself.
// Throughput: one word at a time; ready is low for the whole run.
// Reset: control state clears, sizes go to one, the step limit to zero; the grid
// memory is undefined until loaded, and the cost memory needs no clearing pass.
`default_nettype none
module grid_min_redirect_path_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_idx,
    input  wire logic [15:0]            i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_action,
    input  wire logic [5:0]             i_row,
    input  wire logic [5:0]             i_col,
    input  wire logic [2:0]             i_cell_code,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [gmr_pkg::OUT_W-1:0]   o_best_cost,
    output logic                        o_found
);
    import gmr_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RDW   = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
    localparam int CDW   = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_SEED = 3'd2;
    localparam logic [2:0] ST_CELL = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [2:0] SUB_LAST = 3'd5;

    // storage
    t_code grid_mem [0:CELLS-1];
    t_cost cost_mem [0:1][0:CELLS-1];

    logic [2:0]       r_state, n_state;
    logic [6:0]       r_rows, r_cols;
    logic [15:0]      r_step;
    logic [RDW-1:0]   r_i, n_i;
    logic [CDW-1:0]   r_j, n_j;
    logic [AW-1:0]    r_k, n_k, r_krow, n_krow;
    logic [2:0]       r_sub, n_sub;
    logic [15:0]      r_s, n_s;
    logic             r_same, n_same;
    t_cost            r_best, n_best;
    t_cost            r_v, n_v;
    logic             r_q_ok, r_q_virt;
    t_cost            r_q_vcost;
    t_code            r_q_want;
    t_cost            r_cost_q;
    t_code            r_grid_q;
    logic             r_o_valid, n_o_valid;
    logic [OUT_W-1:0] r_o_best, n_o_best;
    logic             r_o_found, n_o_found;

    logic [RDW-1:0]   w_nr;
    logic [CDW-1:0]   w_nc;
    logic             w_nb_ok, w_virt, w_bank;
    logic [AW-1:0]    w_nb_addr, w_rd_addr;
    t_code            w_want;
    t_cost            w_qcost, w_relaxed;
    t_relax_req       w_req;
    logic             w_load_we, w_cost_we, w_last, w_same_now;
    logic [AW-1:0]    w_load_addr;

    // clamp the size registers to the store; a size of zero counts as one
    always_comb begin
        if (r_rows == 7'd0) begin
            w_nr = RDW'(1);
        end else if (RDW'(r_rows) > RDW'(MAX_ROWS)) begin
            w_nr = RDW'(MAX_ROWS);
        end else begin
            w_nr = RDW'(r_rows);
        end
        if (r_cols == 7'd0) begin
            w_nc = CDW'(1);
        end else if (CDW'(r_cols) > CDW'(MAX_COLS)) begin
            w_nc = CDW'(MAX_COLS);
        end else begin
            w_nc = CDW'(r_cols);
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign w_load_we   = i_valid && o_ready && !i_action
                         && (32'(i_row) < MAX_ROWS) && (32'(i_col) < MAX_COLS);
    assign w_load_addr = AW'(32'(i_row) * MAX_COLS + 32'(i_col));

    // read issue: one neighbor per sub-step, then the cell itself
    always_comb begin
        w_nb_ok   = 1'b1;
        w_nb_addr = r_k;
        w_want    = CODE_GOAL;
        w_bank    = ~r_s[0];
        w_virt    = (r_s == 16'd1);
        case (r_sub)
            3'd0: begin
                w_nb_ok   = (r_i != '0);
                w_nb_addr = r_k - AW'(MAX_COLS);
                w_want    = CODE_DOWN;
                w_bank    = r_s[0];
                w_virt    = (r_s == 16'd0);
            end
            3'd1: begin
                w_nb_ok   = ((r_i + RDW'(1)) < w_nr);
                w_nb_addr = r_k + AW'(MAX_COLS);
                w_want    = CODE_UP;
                w_bank    = r_s[0];
                w_virt    = (r_s == 16'd0);
            end
            3'd2: begin
                w_nb_ok   = (r_j != '0);
                w_nb_addr = r_k - AW'(1);
                w_want    = CODE_RIGHT;
                w_bank    = r_s[0];
                w_virt    = (r_s == 16'd0);
            end
            3'd3: begin
                w_nb_ok   = ((r_j + CDW'(1)) < w_nc);
                w_nb_addr = r_k + AW'(1);
                w_want    = CODE_LEFT;
                w_bank    = r_s[0];
                w_virt    = (r_s == 16'd0);
            end
            default: begin
                w_nb_ok   = 1'b1;
                w_nb_addr = r_k;
                w_want    = CODE_GOAL;
                w_bank    = ~r_s[0];
                w_virt    = (r_s == 16'd1);
            end
        endcase
        w_rd_addr = (r_state == ST_INIT) ? '0 : w_nb_addr;
    end

    assign w_cost_we = (r_state == ST_CELL) && (r_sub == SUB_LAST);

    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            grid_mem[w_load_addr] <= i_cell_code;
        end
        if (w_cost_we) begin
            cost_mem[~r_s[0]][r_k] <= r_v;
        end
        r_grid_q <= grid_mem[w_rd_addr];
        r_cost_q <= cost_mem[w_bank][w_rd_addr];
    end

    // layer zero lives only in logic: start cell at 0, the rest unreached
    always_ff @(posedge i_clk) begin
        r_q_ok    <= w_nb_ok;
        r_q_virt  <= w_virt;
        r_q_vcost <= (w_nb_addr == '0) ? '0 : COST_UNREACHED;
        r_q_want  <= w_want;
    end

    assign w_qcost = r_q_virt ? r_q_vcost : r_cost_q;
    assign w_req   = {r_q_ok, w_qcost, r_grid_q, r_q_want};

    gmr_relax u_relax (
        .i_req  (w_req),
        .i_cur  (r_v),
        .o_next (w_relaxed)
    );

    assign w_last     = ((r_j + CDW'(1)) == w_nc) && ((r_i + RDW'(1)) == w_nr);
    assign w_same_now = r_same && !((r_s != 16'd0) && (w_qcost != r_v));

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_krow    = r_krow;
        n_sub     = r_sub;
        n_s       = r_s;
        n_same    = r_same;
        n_best    = r_best;
        n_v       = r_v;
        n_o_valid = r_o_valid && !i_ready;
        n_o_best  = r_o_best;
        n_o_found = r_o_found;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_action) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_state = ST_SEED;
            end
            ST_SEED: begin
                n_best = (r_grid_q == CODE_GOAL) ? '0 : COST_UNREACHED;
                n_i    = '0;
                n_j    = '0;
                n_k    = '0;
                n_krow = '0;
                n_sub  = '0;
                n_s    = '0;
                n_same = 1'b1;
                n_state = (r_step == 16'd0) ? ST_DONE : ST_CELL;
            end
            ST_CELL: begin
                if (r_sub == 3'd0) begin
                    n_v   = COST_UNREACHED;
                    n_sub = r_sub + 3'd1;
                end else if (r_sub != SUB_LAST) begin
                    n_v   = w_relaxed;
                    n_sub = r_sub + 3'd1;
                end else begin
                    n_sub  = '0;
                    n_same = w_same_now;
                    if ((r_grid_q == CODE_GOAL) && (r_v < r_best)) begin
                        n_best = r_v;
                    end
                    if (w_last) begin
                        n_i    = '0;
                        n_j    = '0;
                        n_k    = '0;
                        n_krow = '0;
                        n_same = 1'b1;
                        n_s    = r_s + 16'd1;
                        // stop on a repeating layer or at the step limit
                        if (((r_s != 16'd0) && w_same_now)
                            || ((17'(r_s) + 17'd1) == 17'(r_step))) begin
                            n_state = ST_DONE;
                        end
                    end else if ((r_j + CDW'(1)) == w_nc) begin
                        n_i    = r_i + RDW'(1);
                        n_j    = '0;
                        n_krow = r_krow + AW'(MAX_COLS);
                        n_k    = r_krow + AW'(MAX_COLS);
                    end else begin
                        n_j = r_j + CDW'(1);
                        n_k = r_k + AW'(1);
                    end
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_found = (r_best != COST_UNREACHED);
                    n_o_best  = (r_best != COST_UNREACHED) ? r_best[OUT_W-1:0] : '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rows    <= 7'd1;
            r_cols    <= 7'd1;
            r_step    <= '0;
            r_sub     <= '0;
            r_s       <= '0;
            r_same    <= 1'b1;
            r_best    <= COST_UNREACHED;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sub     <= n_sub;
            r_s       <= n_s;
            r_same    <= n_same;
            r_best    <= n_best;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROWS: r_rows <= i_cfg_data[6:0];
                    REG_COLS: r_cols <= i_cfg_data[6:0];
                    REG_STEP: r_step <= i_cfg_data;
                    default:  r_step <= r_step;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_krow    <= n_krow;
        r_v       <= n_v;
        r_o_best  <= n_o_best;
        r_o_found <= n_o_found;
    end

    assign o_valid     = r_o_valid;
    assign o_best_cost = r_o_best;
    assign o_found     = r_o_found;
endmodule
`default_nettype wire

[bench/gmr_tb_pkg.sv]
// Bench-side constants shared by the grid path search checker and stimulus.
`timescale 1ns / 1ps
package gmr_tb_pkg;
    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    // Codes past the goal mark all behave as plain cells.
    localparam logic [2:0] CODE_PLAIN    = 3'd5;
    localparam logic [2:0] CODE_SPARE_LO = 3'd6;
    localparam logic [2:0] CODE_SPARE_HI = 3'd7;
endpackage

[bench/gmr_checker.sv]
// Watches the grid path search channels, predicts each run's answer and compares.
`timescale 1ns / 1ps
module gmr_checker
    import gmr_pkg::*;
    import gmr_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_action,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic [2:0]  i_cell_code,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_best_cost,
    input  logic        i_found,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [15:0] cost;
        logic        found;
    } t_answer;

    t_code       cell_map [0:GRID_ROWS*GRID_COLS-1];
    t_cost       sweep [0:2][0:GRID_ROWS*GRID_COLS-1];
    logic [6:0]  rows_q;
    logic [6:0]  cols_q;
    logic [15:0] steps_q;
    t_answer     answers_due [$];
    t_answer     oldest;
    logic [15:0] run_cost;
    logic        run_hit;
    int          mismatches = 0;
    int          due_count = 0;

    assign o_errors  = mismatches;
    assign o_pending = due_count;

    function automatic int fit_dim(logic [6:0] v, int lim);
        if (v == 7'd0) return 1;
        if (int'(v) > lim) return lim;
        return int'(v);
    endfunction

    function automatic t_cost cheaper(t_cost acc, t_cost src, t_code code, t_code dir);
        t_cost c;
        if (src == COST_UNREACHED) return acc;
        c = src + ((code == dir) ? t_cost'(0) : t_cost'(1));
        return (c < acc) ? c : acc;
    endfunction

    // Layered sweep over three rotating layers; stop once a layer repeats the one
    // two moves back, since every later layer then repeats too.
    task automatic solve_run(output logic [15:0] cost, output logic hit);
        int    nr, nc, k, older, cur, nxt, spare;
        bit    have_older, stable;
        t_cost best, v;
        nr = fit_dim(rows_q, GRID_ROWS);
        nc = fit_dim(cols_q, GRID_COLS);
        older = 0;
        cur = 1;
        nxt = 2;
        have_older = 1'b0;
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
                sweep[cur][i*GRID_COLS+j] = COST_UNREACHED;
        sweep[cur][0] = '0;
        best = (cell_map[0] == CODE_GOAL) ? t_cost'(0) : COST_UNREACHED;
        for (int s = 0; s < int'(steps_q); s++) begin
            stable = 1'b1;
            for (int i = 0; i < nr; i++) begin
                for (int j = 0; j < nc; j++) begin
                    k = i*GRID_COLS + j;
                    v = COST_UNREACHED;
                    if (i > 0)
                        v = cheaper(v, sweep[cur][k-GRID_COLS], cell_map[k-GRID_COLS], CODE_DOWN);
                    if (i + 1 < nr)
                        v = cheaper(v, sweep[cur][k+GRID_COLS], cell_map[k+GRID_COLS], CODE_UP);
                    if (j > 0)
                        v = cheaper(v, sweep[cur][k-1], cell_map[k-1], CODE_RIGHT);
                    if (j + 1 < nc)
                        v = cheaper(v, sweep[cur][k+1], cell_map[k+1], CODE_LEFT);
                    sweep[nxt][k] = v;
                    if (cell_map[k] == CODE_GOAL && v < best) best = v;
                    if (have_older && sweep[older][k] != v) stable = 1'b0;
                end
            end
            if (have_older && stable) break;
            spare = older;
            older = cur;
            cur = nxt;
            nxt = spare;
            have_older = 1'b1;
        end
        hit = (best != COST_UNREACHED);
        cost = hit ? best[15:0] : 16'd0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_q = 7'd1;
            cols_q = 7'd1;
            steps_q = 16'd0;
            answers_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected word: best_cost=%0d found=%0d", i_best_cost, i_found);
                    mismatches++;
                end else begin
                    oldest = answers_due.pop_front();
                    if (i_best_cost !== oldest.cost) begin
                        $error("best_cost: expected %0d, got %0d", oldest.cost, i_best_cost);
                        mismatches++;
                    end
                    if (i_found !== oldest.found) begin
                        $error("found: expected %0d, got %0d", oldest.found, i_found);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_RUN) begin
                    solve_run(run_cost, run_hit);
                    answers_due.push_back('{cost: run_cost, found: run_hit});
                end else begin
                    cell_map[int'(i_row)*GRID_COLS + int'(i_col)] = i_cell_code;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROWS: rows_q = i_cfg_data[6:0];
                    REG_COLS: cols_q = i_cfg_data[6:0];
                    REG_STEP: steps_q = i_cfg_data;
                    default: ;
                endcase
            end
        end
        due_count = answers_due.size();
    end
endmodule

[bench/tb.sv]
// Stimulus and verdict for the grid path search block.
`timescale 1ns / 1ps
module tb;
    import gmr_pkg::*;
    import gmr_tb_pkg::*;

    typedef enum int {SHAPE_BOX, SHAPE_TALL, SHAPE_WIDE, SHAPE_LOOP} t_shape;

    localparam int ITEM_GOAL     = 550;
    localparam int RUN_GOAL      = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_ROWS;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        i_action = ACT_LOAD;
    logic [5:0]  i_row = '0;
    logic [5:0]  i_col = '0;
    logic [2:0]  i_cell_code = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_best_cost;
    logic        o_found;
    int          fail_count;
    int          pending;

    int sent = 0;
    int runs_sent = 0;
    int eff_rows = 1;
    int eff_cols = 1;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    t_code arrows [4] = '{CODE_UP, CODE_DOWN, CODE_LEFT, CODE_RIGHT};

    grid_min_redirect_path_dp #(
        .MAX_ROWS(GRID_ROWS),
        .MAX_COLS(GRID_COLS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_action(i_action),
        .i_row(i_row),
        .i_col(i_col),
        .i_cell_code(i_cell_code),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_best_cost(o_best_cost),
        .o_found(o_found)
    );

    gmr_checker u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid),
        .i_in_ready(o_ready),
        .i_action(i_action),
        .i_row(i_row),
        .i_col(i_col),
        .i_cell_code(i_cell_code),
        .i_out_valid(o_valid),
        .i_out_ready(i_ready),
        .i_best_cost(o_best_cost),
        .i_found(o_found),
        .o_errors(fail_count),
        .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic int pace();
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic t_code pick_code();
        int n;
        n = int'($urandom_range(0, 19));
        if (n < 12) return arrows[n % 4];
        if (n < 15) return CODE_GOAL;
        if (n < 18) return CODE_PLAIN;
        return (n == 18) ? CODE_SPARE_LO : CODE_SPARE_HI;
    endfunction

    function automatic int span(logic [6:0] v, int lim);
        if (v == 7'd0) return 1;
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    // Size registers keep only seven bits; sometimes fill the rest with junk.
    function automatic logic [15:0] pad_dim(logic [6:0] v);
        logic [15:0] d;
        d = 16'($urandom);
        if ($urandom_range(0, 1) == 0) d[15:7] = '0;
        d[6:0] = v;
        return d;
    endfunction

    task automatic send_word(input logic act, input logic [5:0] r, input logic [5:0] c,
                             input t_code code);
        int gap;
        gap = pace();
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_action <= act;
        i_row <= r;
        i_col <= c;
        i_cell_code <= code;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic fire_run();
        send_word(ACT_RUN, 6'($urandom), 6'($urandom), t_code'($urandom));
        runs_sent++;
    endtask

    task automatic wait_results();
        @(negedge i_clk) i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // Drain the block, let a trailing load word finish, then rewrite all three registers.
    task automatic configure(input logic [6:0] r, input logic [6:0] c, input logic [15:0] s);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        put_reg(REG_ROWS, pad_dim(r));
        put_reg(REG_COLS, pad_dim(c));
        put_reg(REG_STEP, s);
        eff_rows = span(r, GRID_ROWS);
        eff_cols = span(c, GRID_COLS);
    endtask

    task automatic fill_region();
        for (int i = 0; i < eff_rows; i++)
            for (int j = 0; j < eff_cols; j++)
                send_word(ACT_LOAD, 6'(i), 6'(j), pick_code());
    endtask

    // Result side: per-word stall, plus one long hold-off on request.
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge i_clk) i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = pace();
            if (stall > 0) begin
                @(negedge i_clk) i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        t_shape      shape;
        int          n;
        int          variant;
        logic [6:0]  rv;
        logic [6:0]  cv;
        logic [15:0] sv;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Reset sizes: a single cell and no moves.
        send_word(ACT_LOAD, 6'd0, 6'd0, CODE_PLAIN);
        fire_run();
        send_word(ACT_LOAD, 6'd0, 6'd0, CODE_GOAL);
        fire_run();

        // Zero rows acts as one; arrow toward the goal is free, away costs one.
        configure(7'd0, 7'd2, 16'd3);
        send_word(ACT_LOAD, 6'd0, 6'd0, CODE_RIGHT);
        send_word(ACT_LOAD, 6'd0, 6'd1, CODE_GOAL);
        fire_run();
        send_word(ACT_LOAD, 6'd0, 6'd0, CODE_LEFT);
        fire_run();

        configure(7'd2, 7'd2, 16'd4);
        send_word(ACT_LOAD, 6'd0, 6'd0, CODE_DOWN);
        send_word(ACT_LOAD, 6'd1, 6'd0, CODE_RIGHT);
        send_word(ACT_LOAD, 6'd0, 6'd1, CODE_UP);
        send_word(ACT_LOAD, 6'd1, 6'd1, CODE_GOAL);
        fire_run();
        // Unused codes behave as plain cells.
        send_word(ACT_LOAD, 6'd0, 6'd0, CODE_SPARE_LO);
        send_word(ACT_LOAD, 6'd1, 6'd0, CODE_SPARE_HI);
        fire_run();
        // Corners of the store, outside the active grid.
        send_word(ACT_LOAD, 6'd63, 6'd63, CODE_GOAL);
        send_word(ACT_LOAD, 6'd0, 6'd63, CODE_UP);
        send_word(ACT_LOAD, 6'd63, 6'd0, CODE_PLAIN);
        fire_run();

        // Stall the result side long enough that run words back up at the input.
        calm = 1'b0;
        configure(7'd2, 7'd2, 16'd3);
        fill_region();
        hold_req = 1'b1;
        repeat (4) fire_run();

        while (sent < ITEM_GOAL || runs_sent < RUN_GOAL) begin
            calm = ($urandom_range(0, 3) == 0);
            n = int'($urandom_range(0, 9));
            shape = (n == 0) ? SHAPE_TALL : (n == 1) ? SHAPE_WIDE :
                    (n == 2) ? SHAPE_LOOP : SHAPE_BOX;
            variant = int'($urandom_range(0, 2));
            case (shape)
                SHAPE_TALL: begin
                    rv = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'($urandom_range(65, 127));
                    cv = 7'($urandom_range(0, 1));
                    sv = 16'($urandom_range(0, 24));
                end
                SHAPE_WIDE: begin
                    rv = 7'($urandom_range(0, 1));
                    cv = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'($urandom_range(65, 127));
                    sv = 16'($urandom_range(0, 24));
                end
                SHAPE_LOOP: begin
                    // Shapes that settle into a fixed cycle, so a large step count ends early.
                    rv = (variant == 2) ? 7'd2 : 7'($urandom_range(0, 1));
                    cv = (variant == 1) ? 7'd2 : 7'($urandom_range(0, 1));
                    sv = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
                end
                default: begin
                    rv = 7'($urandom_range(0, 4));
                    cv = 7'($urandom_range(0, 4));
                    sv = 16'($urandom_range(0, 20));
                end
            endcase
            configure(rv, cv, sv);
            if (shape != SHAPE_LOOP) begin
                fill_region();
            end else if (variant == 0) begin
                send_word(ACT_LOAD, 6'd0, 6'd0, pick_code());
            end else if (variant == 1) begin
                send_word(ACT_LOAD, 6'd0, 6'd0, CODE_RIGHT);
                send_word(ACT_LOAD, 6'd0, 6'd1, CODE_LEFT);
            end else begin
                send_word(ACT_LOAD, 6'd0, 6'd0, CODE_DOWN);
                send_word(ACT_LOAD, 6'd1, 6'd0, CODE_UP);
            end
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 4)) begin
                    // Keep the looping shapes intact: write only below them.
                    if (shape == SHAPE_LOOP)
                        send_word(ACT_LOAD, 6'($urandom_range(2, 63)), 6'($urandom), pick_code());
                    else if ($urandom_range(0, 1) == 0)
                        send_word(ACT_LOAD, 6'($urandom_range(0, eff_rows - 1)),
                                  6'($urandom_range(0, eff_cols - 1)), pick_code());
                    else
                        send_word(ACT_LOAD, 6'($urandom), 6'($urandom), pick_code());
                end
                fire_run();
                if ($urandom_range(0, 4) == 0) wait_results();
            end
        end

        wait_results();
        repeat (64) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
